>>> src/bblur_pkg.sv
`timescale 1ns / 1ps
// bblur_pkg: shared types and constants for the 3x3 edge-aware box blur
// used by every module of the block and by its checker

package bblur_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CNT_W       = COL_W + 1;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int ROW_W       = 16;
    localparam int RING_ROWS   = 4;
    localparam int SLOT_W      = $clog2(RING_ROWS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int PADDR_W     = 3;
    localparam int APB_DATA_W  = 32;

    // register index as decoded from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef logic [23:0] rgb_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } pix_out_t;

    // effective frame geometry plus restart strobe from the register file
    typedef struct packed {
        logic                restart;
        logic [CNT_W-1:0]    width;
        logic [HEIGHT_W-1:0] height;
    } frame_ctl_t;

    // one command from the front end to the filter back end
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [COL_W-1:0]  wr_col;
        rgb_t              wr_pixel;
        logic              rd_en;
        logic [SLOT_W-1:0] row_slot;
        logic              top_ok;
        logic              bot_ok;
        logic              first_col;
        logic              right_ok;
        logic [COL_W-1:0]  rd_col;
        logic              frame_end;
    } blur_cmd_t;

endpackage

>>> src/bblur_front.sv
`timescale 1ns / 1ps
// bblur_front: accepts pixels and drain transactions, tracks input and output
// positions and issues store/compute commands; depends on bblur_pkg

module bblur_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bblur_pkg::frame_ctl_t ctl,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bblur_pkg::pix_in_t   s_data,
    input  logic                 q_full,
    output logic                 push,
    output bblur_pkg::blur_cmd_t push_cmd
);
    import bblur_pkg::*;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             primed_reg, primed_next;

    logic             accept;
    logic             is_pix;
    logic [CNT_W-1:0] in_col_inc;
    logic [ROW_W:0]   in_row_inc;
    logic [COL_W-1:0] in_col_upd;
    logic [ROW_W-1:0] in_row_upd;
    logic             primed_upd;
    logic [CNT_W-1:0] out_col_inc;
    logic [ROW_W:0]   out_row_inc;
    logic             right_ok;
    logic             bot_ok;
    logic [ROW_W-1:0] need_row;
    logic [CNT_W-1:0] need_col;
    logic             out_ready;
    logic             frame_done;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign is_pix  = (s_data.req_type == REQ_PIXEL) && !primed_reg;

    always_comb begin
        in_col_inc = {1'b0, in_col_reg} + CNT_W'(1);
        in_row_inc = {1'b0, in_row_reg} + (ROW_W+1)'(1);
        in_col_upd = in_col_reg;
        in_row_upd = in_row_reg;
        primed_upd = primed_reg;
        if (is_pix) begin
            if (in_col_inc >= ctl.width) begin
                in_col_upd = '0;
                in_row_upd = in_row_inc[ROW_W-1:0];
                if (in_row_inc >= {1'b0, ctl.height}) begin
                    primed_upd = 1'b1;
                end
            end else begin
                in_col_upd = in_col_inc[COL_W-1:0];
            end
        end

        // last neighbor position the next output waits for, clamped to the frame
        out_col_inc = {1'b0, out_col_reg} + CNT_W'(1);
        out_row_inc = {1'b0, out_row_reg} + (ROW_W+1)'(1);
        right_ok    = out_col_inc < ctl.width;
        bot_ok      = out_row_inc < {1'b0, ctl.height};
        need_row    = bot_ok ? out_row_inc[ROW_W-1:0] : ROW_W'(ctl.height - HEIGHT_W'(1));
        need_col    = right_ok ? out_col_inc : ctl.width - CNT_W'(1);

        out_ready  = primed_upd || (in_row_upd > need_row) ||
                     ((in_row_upd == need_row) && ({1'b0, in_col_upd} > need_col));
        frame_done = out_ready && !right_ok && !bot_ok;
    end

    always_comb begin
        push_cmd.wr_en     = is_pix;
        push_cmd.wr_slot   = in_row_reg[SLOT_W-1:0];
        push_cmd.wr_col    = in_col_reg;
        push_cmd.wr_pixel  = {s_data.in_red, s_data.in_green, s_data.in_blue};
        push_cmd.rd_en     = out_ready;
        push_cmd.row_slot  = out_row_reg[SLOT_W-1:0];
        push_cmd.top_ok    = out_row_reg != '0;
        push_cmd.bot_ok    = bot_ok;
        push_cmd.first_col = out_col_reg == '0;
        push_cmd.right_ok  = right_ok;
        // the first output of a row also reads column 1 on the second port
        push_cmd.rd_col    = (out_col_reg == '0) ? '0 : out_col_inc[COL_W-1:0];
        push_cmd.frame_end = frame_done;
        push               = accept && (is_pix || out_ready);
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        primed_next  = primed_reg;
        if (ctl.restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            primed_next  = 1'b0;
        end else if (accept) begin
            in_col_next = in_col_upd;
            in_row_next = in_row_upd;
            primed_next = primed_upd;
            if (out_ready) begin
                if (right_ok) begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end else begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[ROW_W-1:0];
                end
            end
            if (frame_done) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                primed_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            primed_reg  <= 1'b0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            primed_reg  <= primed_next;
        end
    end

endmodule

>>> src/bblur_queue.sv
`timescale 1ns / 1ps
// bblur_queue: short command queue between the front and back ends
// depends on bblur_pkg for the command type and depth

module bblur_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  bblur_pkg::blur_cmd_t  push_cmd,
    input  logic                  pop,
    output bblur_pkg::blur_cmd_t  head,
    output logic                  full,
    output logic                  empty
);
    import bblur_pkg::*;

    blur_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (QPTR_W+1)'(1);
            2'b01:   count_next = count_reg - (QPTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/bblur_back.sv
`timescale 1ns / 1ps
// bblur_back: row memories, sliding 3x3 window, masked sums and rounded mean
// with an output register; depends on bblur_pkg

module bblur_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bblur_pkg::blur_cmd_t head,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bblur_pkg::pix_out_t  m_data
);
    import bblur_pkg::*;

    localparam logic [12:0] DIV3_MUL = 13'd2731;  // ceil(2^13 / 3)
    localparam logic [11:0] DIV9_MUL = 12'd1821;  // ceil(2^14 / 9)

    logic      adv;
    rgb_t      rda_reg [RING_ROWS];
    rgb_t      rdb_reg [RING_ROWS];
    logic      byp_a_reg [RING_ROWS];
    logic      byp_b_reg [RING_ROWS];
    rgb_t      wr_pixel_reg;
    logic      s1_valid_reg;
    blur_cmd_t s1_cmd_reg;

    rgb_t              col_a [RING_ROWS];
    rgb_t              col_b [RING_ROWS];
    rgb_t              win [3][3];
    rgb_t              cur_centre [3];
    rgb_t              cur_right [3];
    rgb_t              hold_left_reg [3];
    rgb_t              hold_centre_reg [3];
    logic              row_ok [3];
    logic              col_ok [3];
    logic [SLOT_W-1:0] slot [3];
    logic [11:0]       sum_next [3];
    logic [1:0]        rows_n;
    logic [1:0]        cols_n;
    logic [3:0]        count_next;

    logic        s2_valid_reg;
    logic [11:0] sum_reg [3];
    logic [3:0]  count_reg;
    logic        frame_end_reg;

    logic     m_valid_reg;
    pix_out_t m_data_reg;

    function automatic logic [7:0] round_mean(input logic [11:0] sum, input logic [3:0] cnt);
        logic [12:0] x;
        logic [11:0] y2;
        logic [11:0] y4;
        logic [24:0] p3;
        logic [23:0] p9;
        logic [7:0]  q;
        // (2*sum + cnt) / (2*cnt) split into a shift and a divide by 3 or 9
        x  = {sum, 1'b0} + 13'(cnt);
        y2 = x[12:1];
        y4 = 12'(x[12:2]);
        p3 = 25'(y2) * 25'(DIV3_MUL);
        p9 = 24'(y2) * 24'(DIV9_MUL);
        case (cnt)
            4'd1:    q = y2[7:0];
            4'd2:    q = y4[7:0];
            4'd3:    q = p3[20:13];
            4'd4:    q = x[10:3];
            4'd6: begin
                p3 = 25'(y4) * 25'(DIV3_MUL);
                q  = p3[20:13];
            end
            4'd9:    q = p9[21:14];
            default: q = '0;
        endcase
        return q;
    endfunction

    // the whole pipe moves when the output register can take a result
    assign adv = !m_valid_reg || m_ready;
    assign pop = adv && !q_empty;

    // one row memory per ring slot, one write port, two read ports
    for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
        rgb_t bank_mem [MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (pop && head.wr_en && head.wr_slot == SLOT_W'(b)) begin
                bank_mem[head.wr_col] <= head.wr_pixel;
            end
            if (adv) begin
                rda_reg[b]   <= bank_mem[head.rd_col];
                rdb_reg[b]   <= bank_mem[COL_W'(1)];
                byp_a_reg[b] <= pop && head.wr_en && head.wr_slot == SLOT_W'(b) &&
                                head.wr_col == head.rd_col;
                byp_b_reg[b] <= pop && head.wr_en && head.wr_slot == SLOT_W'(b) &&
                                head.wr_col == COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wr_pixel_reg <= head.wr_pixel;
            s1_cmd_reg   <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= pop && head.rd_en;
        end
    end

    // window assembly and masked sums
    always_comb begin
        for (int b = 0; b < RING_ROWS; b++) begin
            col_a[b] = byp_a_reg[b] ? wr_pixel_reg : rda_reg[b];
            col_b[b] = byp_b_reg[b] ? wr_pixel_reg : rdb_reg[b];
        end
        slot[0] = s1_cmd_reg.row_slot - SLOT_W'(1);
        slot[1] = s1_cmd_reg.row_slot;
        slot[2] = s1_cmd_reg.row_slot + SLOT_W'(1);
        row_ok[0] = s1_cmd_reg.top_ok;
        row_ok[1] = 1'b1;
        row_ok[2] = s1_cmd_reg.bot_ok;
        col_ok[0] = !s1_cmd_reg.first_col;
        col_ok[1] = 1'b1;
        col_ok[2] = s1_cmd_reg.right_ok;
        for (int r = 0; r < 3; r++) begin
            cur_centre[r] = s1_cmd_reg.first_col ? col_a[slot[r]] : hold_centre_reg[r];
            cur_right[r]  = s1_cmd_reg.first_col ? col_b[slot[r]] : col_a[slot[r]];
            win[0][r]     = hold_left_reg[r];
            win[1][r]     = cur_centre[r];
            win[2][r]     = cur_right[r];
        end
        for (int ch = 0; ch < 3; ch++) begin
            sum_next[ch] = '0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    if (col_ok[c] && row_ok[r]) begin
                        sum_next[ch] = sum_next[ch] + 12'(win[c][r][8*(2-ch) +: 8]);
                    end
                end
            end
        end
        rows_n     = 2'd1 + 2'(s1_cmd_reg.top_ok) + 2'(s1_cmd_reg.bot_ok);
        cols_n     = 2'd1 + 2'(!s1_cmd_reg.first_col) + 2'(s1_cmd_reg.right_ok);
        count_next = 4'(rows_n) * 4'(cols_n);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                sum_reg[ch] <= sum_next[ch];
            end
            count_reg     <= count_next;
            frame_end_reg <= s1_cmd_reg.frame_end;
            if (s1_valid_reg) begin
                for (int r = 0; r < 3; r++) begin
                    hold_left_reg[r]   <= cur_centre[r];
                    hold_centre_reg[r] <= cur_right[r];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.out_red   <= round_mean(sum_reg[0], count_reg);
            m_data_reg.out_green <= round_mean(sum_reg[1], count_reg);
            m_data_reg.out_blue  <= round_mean(sum_reg[2], count_reg);
            m_data_reg.frame_end <= frame_end_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/box_blur_3x3_edge_aware_top.sv
`timescale 1ns / 1ps
// 3x3 edge-aware box blur over a raster RGB stream.
// Input channel s_*: one transaction per pixel (req_type pixel) or per drain
// request (req_type drain). Output channel m_*: one rounded per-channel mean
// for each pixel of the frame, in raster order, frame_end set on the last one.
// An output appears once its in-frame neighbors have arrived, one row plus one
// pixel after its centre; after the last pixel of the frame, drain
// transactions release the remaining outputs one each.
// Throughput: one transaction per clock while s_ready is high. A result that a
// transaction releases shows on m_valid once it has passed the command queue, the
// memory read, window sum and divide registers.
// Configuration over APB: frame_width at 0x0, frame_height at 0x4; a write
// restarts the frame. Reset sets width 1024, height 1 and clears all counters
// and the pipeline. When m_ready is low the back end holds its result, the
// 4-entry command queue fills and s_ready then drops.
// Depends on bblur_pkg, bblur_front, bblur_queue, bblur_back.

module box_blur_3x3_edge_aware_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bblur_pkg::pix_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bblur_pkg::pix_out_t                  m_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bblur_pkg::PADDR_W-1:0]        paddr,
    input  logic [bblur_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bblur_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import bblur_pkg::*;

    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic                cfg_wr;
    frame_ctl_t          ctl;
    blur_cmd_t           push_cmd;
    blur_cmd_t           head;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  width_next  = pwdata[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: height_next = pwdata[HEIGHT_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(MAX_WIDTH);
            height_reg <= HEIGHT_W'(1);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // zero acts as one, width clamps to the row memory depth
    always_comb begin
        ctl.restart = cfg_wr;
        if (width_reg == '0) begin
            ctl.width = CNT_W'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            ctl.width = CNT_W'(MAX_WIDTH);
        end else begin
            ctl.width = CNT_W'(width_reg);
        end
        ctl.height = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    bblur_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    bblur_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    bblur_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> src/bblur_checker.sv
`timescale 1ns / 1ps
// bblur_port_checks: port-level assertions for the box blur top level
// depends on bblur_pkg; attached to box_blur_3x3_edge_aware_top by bind

module bblur_port_checks (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input bblur_pkg::pix_in_t               s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input bblur_pkg::pix_out_t              m_data,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [bblur_pkg::PADDR_W-1:0]    paddr,
    input logic [bblur_pkg::APB_DATA_W-1:0] pwdata,
    input logic [bblur_pkg::APB_DATA_W-1:0] prdata,
    input logic                             pready
);
    import bblur_pkg::*;

    // a waiting input transaction keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("input changed while waiting");

    // a stalled result transaction keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // frame_width reads back what was written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_WIDTH) |=>
        (paddr[2] != REG_FRAME_WIDTH ||
         prdata[WIDTH_W-1:0] == $past(pwdata[WIDTH_W-1:0])))
        else $error("frame_width readback mismatch");

    // no register is wider than the height field
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> (prdata[APB_DATA_W-1:HEIGHT_W] == '0))
        else $error("register readback has stray upper bits");

endmodule

bind box_blur_3x3_edge_aware_top bblur_port_checks u_port_checks (.*);

>>> sim/bblur_checker.sv
`timescale 1ns / 1ps
// bblur_checker: watches the pixel, result and APB ports of the 3x3 box blur,
// keeps its own line ring and frame counters and compares every result transaction
// depends on bblur_pkg

module bblur_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  bblur_pkg::pix_in_t               s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  bblur_pkg::pix_out_t              m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bblur_pkg::PADDR_W-1:0]    paddr,
    input  logic [bblur_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                             pready,
    output int unsigned                      results_due,
    output int unsigned                      mismatch_count
);
    import bblur_pkg::*;

    logic [WIDTH_W-1:0]  frame_width;
    logic [HEIGHT_W-1:0] frame_height;
    rgb_t                line_ring [RING_ROWS][MAX_WIDTH];
    int unsigned         in_col;
    int unsigned         in_row;
    int unsigned         out_col;
    int unsigned         out_row;
    bit                  frame_in;
    pix_out_t            blur_expected [$];
    int unsigned         fails = 0;

    function automatic int unsigned active_width();
        if (frame_width == 0)
            return 1;
        if (frame_width > MAX_WIDTH)
            return MAX_WIDTH;
        return frame_width;
    endfunction

    function automatic int unsigned active_height();
        return (frame_height == 0) ? 1 : frame_height;
    endfunction

    task automatic restart_counters();
        in_col   = 0;
        in_row   = 0;
        out_col  = 0;
        out_row  = 0;
        frame_in = 1'b0;
    endtask

    task automatic report_failure(input string what);
        fails++;
        if (fails <= 10)
            $display("%0t blur check: %s", $time, what);
    endtask

    // store the pixel, then release the oldest output whose neighbors are all in
    task automatic absorb_item(input pix_in_t item);
        int unsigned w;
        int unsigned h;
        int unsigned near_row;
        int unsigned near_col;
        int unsigned cnt;
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int          r;
        int          c;
        bit          ready;
        rgb_t        px;
        pix_out_t    res;
        w = active_width();
        h = active_height();
        if (item.req_type == REQ_PIXEL && !frame_in) begin
            line_ring[in_row % RING_ROWS][in_col] = {item.in_red, item.in_green, item.in_blue};
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                    frame_in = 1'b1;
            end
        end
        near_row = (out_row + 1 < h) ? out_row + 1 : h - 1;
        near_col = (out_col + 1 < w) ? out_col + 1 : w - 1;
        ready = frame_in || in_row > near_row || (in_row == near_row && in_col > near_col);
        if (ready) begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            cnt   = 0;
            for (r = int'(out_row) - 1; r <= int'(out_row) + 1; r++) begin
                for (c = int'(out_col) - 1; c <= int'(out_col) + 1; c++) begin
                    if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w)) begin
                        px = line_ring[r % RING_ROWS][c];
                        sum_r += px[23:16];
                        sum_g += px[15:8];
                        sum_b += px[7:0];
                        cnt++;
                    end
                end
            end
            // round half up over the in-frame neighbors only
            res.out_red   = 8'((2 * sum_r + cnt) / (2 * cnt));
            res.out_green = 8'((2 * sum_g + cnt) / (2 * cnt));
            res.out_blue  = 8'((2 * sum_b + cnt) / (2 * cnt));
            res.frame_end = 1'b0;
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
                if (out_row >= h) begin
                    res.frame_end = 1'b1;
                    restart_counters();
                end
            end
            blur_expected.push_back(res);
        end
    endtask

    always @(posedge aclk) begin : watch
        pix_out_t want;
        if (!aresetn) begin
            frame_width  = WIDTH_W'(MAX_WIDTH);
            frame_height = HEIGHT_W'(1);
            restart_counters();
            blur_expected.delete();
        end else begin
            // a result never comes from the transaction accepted at the same edge
            if (m_valid && m_ready) begin
                if (blur_expected.size() == 0) begin
                    report_failure($sformatf("result with none pending: r=%0d g=%0d b=%0d end=%0b",
                        m_data.out_red, m_data.out_green, m_data.out_blue, m_data.frame_end));
                end else begin
                    want = blur_expected.pop_front();
                    if (m_data.out_red !== want.out_red || m_data.out_green !== want.out_green ||
                        m_data.out_blue !== want.out_blue ||
                        m_data.frame_end !== want.frame_end) begin
                        report_failure($sformatf(
                            "expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                            want.out_red, want.out_green, want.out_blue, want.frame_end,
                            m_data.out_red, m_data.out_green, m_data.out_blue,
                            m_data.frame_end));
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_FRAME_WIDTH)
                    frame_width = pwdata[WIDTH_W-1:0];
                else
                    frame_height = pwdata[HEIGHT_W-1:0];
                restart_counters();
                blur_expected.delete();
            end
            if (s_valid && s_ready)
                absorb_item(s_data);
        end
        results_due    <= blur_expected.size();
        mismatch_count <= fails;
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// testbench: drives pixel frames, drain requests and APB geometry writes into
// the 3x3 box blur and gives the verdict from the blur checker
// depends on bblur_pkg, box_blur_3x3_edge_aware_top and bblur_checker

module testbench;
    import bblur_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 5000;
    localparam int ITEM_BUDGET   = 1050;
    localparam int CALM_ITEMS    = 880;

    localparam logic [PADDR_W-1:0] ADDR_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    pix_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    pix_out_t              m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned results_due;
    int unsigned mismatch_count;
    int unsigned quiet_cycles = 0;
    int unsigned items_sent   = 0;
    int unsigned frame_w;
    int unsigned frame_h;
    bit          calm;
    bit          sender_gaps;
    bit          noisy;

    box_blur_3x3_edge_aware_top u_dut (.*);

    bblur_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        @(posedge aclk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // result side: stall bursts, single cycles and long stretches with no stall
    initial begin
        m_ready = 1'b1;
        forever begin
            @(posedge aclk);
            if (!calm) begin
                case ($urandom_range(0, 9))
                    0: begin
                        m_ready <= 1'b0;
                        repeat ($urandom_range(1, 11)) @(posedge aclk);
                        m_ready <= 1'b1;
                    end
                    1: repeat ($urandom_range(20, 200)) @(posedge aclk);
                    default: ;
                endcase
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int unsigned flush_count();
        return (frame_h == 1) ? 4 : frame_w + 3;
    endfunction

    task automatic feed_item(input logic req, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        if (sender_gaps && !calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{req_type: req, in_red: r, in_green: g, in_blue: b};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic await_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0)
            @(posedge aclk);
        // drains that release nothing may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned raw_w, input int unsigned raw_h);
        await_results();
        reg_write(ADDR_WIDTH, raw_w);
        reg_write(ADDR_HEIGHT, raw_h);
        frame_w = (raw_w == 0) ? 1 : (raw_w > MAX_WIDTH) ? MAX_WIDTH : raw_w;
        frame_h = (raw_h == 0) ? 1 : raw_h;
    endtask

    task automatic feed_frame(input int unsigned pixels, input int unsigned drains,
                              input bit tail_pixel);
        int unsigned i;
        for (i = 0; i < pixels; i++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                feed_item(REQ_DRAIN, rand_byte(), rand_byte(), rand_byte());
            if ($urandom_range(0, 299) == 0)
                await_results();
            feed_item(REQ_PIXEL, rand_byte(), rand_byte(), rand_byte());
        end
        // a pixel past the frame end only pushes out a pending output
        if (tail_pixel)
            feed_item(REQ_PIXEL, rand_byte(), rand_byte(), rand_byte());
        repeat (drains) feed_item(REQ_DRAIN, rand_byte(), rand_byte(), rand_byte());
    endtask

    initial begin : stimulus
        int unsigned k;
        int unsigned phase;
        int unsigned sel;
        int unsigned total;
        int unsigned raw_w;
        int unsigned raw_h;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        calm        = 1'b0;
        sender_gaps = 1'b1;
        noisy       = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // geometry straight out of reset: one full-width row, cut short by the next write
        frame_w = MAX_WIDTH;
        frame_h = 1;
        feed_frame($urandom_range(40, 80), 2, 1'b0);

        // zero registers act as a single pixel frame, then a drain with nothing ready
        set_geometry(0, 0);
        feed_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        feed_item(REQ_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        feed_item(REQ_PIXEL, 8'h00, 8'h00, 8'h00);

        // 3x3 frame: corner, edge and center divisors over alternating extremes
        set_geometry(3, 3);
        for (k = 0; k < 9; k++) begin
            if (k == 2)
                feed_item(REQ_DRAIN, 8'h00, 8'h00, 8'h00);
            if (k == 5)
                await_results();
            feed_item(REQ_PIXEL, (k % 2) ? 8'hFF : 8'h00, (k % 2) ? 8'h00 : 8'hFF, 8'(k * 31));
        end
        feed_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        repeat (5) feed_item(REQ_DRAIN, 8'h00, 8'h00, 8'h00);

        phase = 0;
        while (items_sent < ITEM_BUDGET) begin
            calm        = (items_sent >= CALM_ITEMS);
            sender_gaps = ($urandom_range(0, 3) != 0);
            noisy       = ($urandom_range(0, 2) == 0);
            sel         = (phase < 2) ? phase : $urandom_range(0, 39);
            case (sel)
                // wide rows, cut short by the next register write
                0: begin
                    raw_w = $urandom_range(0, 1) ? $urandom_range(1025, 2047)
                                                 : $urandom_range(1000, 1024);
                    set_geometry(raw_w, 1);
                    feed_frame($urandom_range(20, 80), $urandom_range(0, 3), 1'b0);
                end
                // very tall frames, cut short as well
                1: begin
                    raw_h = $urandom_range(0, 1) ? 65535 : $urandom_range(100, 65535);
                    set_geometry($urandom_range(1, 3), raw_h);
                    feed_frame($urandom_range(20, 60), 2, 1'b0);
                end
                default: begin
                    if (sel < 5) begin
                        raw_w = $urandom_range(1, 3);
                        raw_h = $urandom_range(13, 40);
                    end else begin
                        raw_w = $urandom_range(0, 16);
                        raw_h = $urandom_range(0, 12);
                    end
                    set_geometry(raw_w, raw_h);
                    total = frame_w * frame_h;
                    if ($urandom_range(0, 9) == 0)
                        feed_frame($urandom_range(1, total), $urandom_range(0, 2), 1'b0);
                    else
                        feed_frame(total, flush_count(), total > 1 && $urandom_range(0, 1));
                end
            endcase
            phase++;
        end

        calm = 1'b1;
        await_results();
        if (mismatch_count == 0 && results_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
